/* rtl/core/ckt_pkg.sv */
package ckt_pkg;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_SAT       = 3'd3;
    localparam logic [2:0] ST_RANGE     = 3'd4;

    localparam int unsigned PRESET_N     = 8;
    localparam int unsigned PRESET_COUNT = 100;

    localparam logic [15:0] PRESET_KEYS [PRESET_N] = '{
        16'd1, 16'd5, 16'd10, 16'd20, 16'd50, 16'd100, 16'd200, 16'd500
    };

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic       capture;
        logic       upd;
        logic [1:0] cmd;
        logic       append;
    } cell_ctl_t;

    // passed from a cell to its right-hand neighbor
    typedef struct packed {
        logic valid;
        logic seen;
        logic del;
    } cell_link_t;

    // per-cell report gathered by the top level
    typedef struct packed {
        logic match;
        logic pick;
        logic sat;
    } cell_rep_t;

    function automatic logic [15:0] preset_key(input int unsigned idx);
        logic [15:0] r;
        r = '0;
        for (int unsigned i = 0; i < PRESET_N; i++)
        begin
            if (idx == i)
            begin
                r = PRESET_KEYS[i];
            end
        end
        return r;
    endfunction

endpackage

/* rtl/core/ckt_cell.sv */
module ckt_cell #(
    parameter int INDEX = 0,
    parameter int KW    = 16,
    parameter int CW    = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ckt_pkg::cell_ctl_t     ctl,
    input  logic [KW-1:0]          cmd_key,
    input  logic [3:0]             pos,
    input  ckt_pkg::cell_link_t    left,
    output ckt_pkg::cell_link_t    right,
    input  logic [KW-1:0]          nxt_key,
    input  logic [CW-1:0]          nxt_count,
    input  logic                   nxt_valid,
    output logic [KW-1:0]          stored_key,
    output logic [CW-1:0]          stored_count,
    output logic                   stored_valid,
    output ckt_pkg::cell_rep_t     rep,
    output logic [KW-1:0]          pick_key,
    output logic [CW-1:0]          pick_count
);

    localparam logic [CW-1:0] CMAX    = '1;
    localparam logic [CW-1:0] PRE_CNT =
        (CW >= 7) ? CW'(ckt_pkg::PRESET_COUNT) : CMAX;
    localparam bool_preset = (INDEX < int'(ckt_pkg::PRESET_N));
    localparam logic [KW-1:0] RST_KEY =
        bool_preset ? KW'(ckt_pkg::preset_key(INDEX)) : '0;
    localparam logic [CW-1:0] RST_CNT = bool_preset ? PRE_CNT : '0;
    localparam logic RST_VALID = bool_preset;

    logic [KW-1:0] key_reg, key_next;
    logic [CW-1:0] count_reg, count_next;
    logic          valid_reg, valid_next;
    logic          match_reg, match_next;

    logic          hit;
    logic          at_max;
    logic          own_del;
    logic [CW-1:0] cnt_inc;
    logic [CW-1:0] rpt_count;
    logic          pick;

    always_comb
    begin
        hit     = match_reg && !left.seen;
        at_max  = (count_reg == CMAX);
        // a stored zero counts as the last unit too
        own_del = hit && (ctl.cmd == ckt_pkg::CMD_REMOVE) && (count_reg <= CW'(1));
        cnt_inc = at_max ? count_reg : count_reg + CW'(1);

        right.valid = valid_reg;
        right.seen  = left.seen | match_reg;
        right.del   = left.del | own_del;

        unique case (ctl.cmd)
            ckt_pkg::CMD_ADD:    rpt_count = cnt_inc;
            ckt_pkg::CMD_REMOVE: rpt_count = own_del ? '0 : count_reg - CW'(1);
            default:             rpt_count = count_reg;
        endcase

        if (ctl.cmd == ckt_pkg::CMD_READ)
        begin
            pick = valid_reg && (INDEX == int'(pos));
        end
        else
        begin
            pick = hit;
        end

        rep.match = valid_reg && (key_reg == cmd_key);
        rep.pick  = pick;
        rep.sat   = hit && (ctl.cmd == ckt_pkg::CMD_ADD) && at_max;

        pick_key   = pick ? key_reg : '0;
        pick_count = pick ? rpt_count : '0;

        stored_key   = key_reg;
        stored_count = count_reg;
        stored_valid = valid_reg;
    end

    always_comb
    begin
        key_next   = key_reg;
        count_next = count_reg;
        valid_next = valid_reg;
        match_next = match_reg;

        if (ctl.capture)
        begin
            match_next = rep.match;
        end

        if (ctl.upd)
        begin
            unique case (ctl.cmd)
                ckt_pkg::CMD_ADD:
                begin
                    if (hit)
                    begin
                        count_next = cnt_inc;
                    end
                    else if (ctl.append && !valid_reg && left.valid)
                    begin
                        // first free cell takes the new key
                        key_next   = cmd_key;
                        count_next = CW'(1);
                        valid_next = 1'b1;
                    end
                end
                ckt_pkg::CMD_REMOVE:
                begin
                    if (right.del)
                    begin
                        key_next   = nxt_key;
                        count_next = nxt_count;
                        valid_next = nxt_valid;
                    end
                    else if (hit)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= RST_KEY;
            count_reg <= RST_CNT;
            valid_reg <= RST_VALID;
            match_reg <= 1'b0;
        end
        else
        begin
            key_reg   <= key_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

endmodule

/* rtl/core/counted_key_table.sv */
// Ordered table of distinct keys with a count per key, held in a row of
// CAPACITY cells. Each command has two steps: when it is accepted every cell
// compares the key against its entry at once and registers the match; in the
// update step the first matching cell updates, or the first free cell takes an
// appended key, or a delete shifts each later cell down from its right neighbor.
// The result then sits in an output register, and the next command is taken
// while it waits; an update only stalls when that register is still full.
// After reset the table holds keys 1, 5, 10, 20, 50, 100, 200, 500 with count
// 100 each. An add to a full table is dropped and reported, counts saturate.
module counted_key_table #(
    parameter int CAPACITY   = 16,
    parameter int KEY_BITS   = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // key[15:0], position[19:16], zero pad
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // count[15:0], key_out[31:16], occupancy[36:32], pad
    output logic [3:0]  m_tuser    // found[0], status[3:1]
);

    localparam int KW = (KEY_BITS < 16) ? KEY_BITS : 16;
    localparam int CW = COUNT_BITS;
    localparam int UW = $clog2(CAPACITY + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic          state_reg, state_next;
    logic [1:0]    cmd_reg, cmd_next;
    logic [KW-1:0] key_reg, key_next;
    logic [3:0]    pos_reg, pos_next;
    logic          found_reg, found_next;
    logic [UW-1:0] used_reg, used_next;

    logic          out_valid_reg, out_valid_next;
    logic          out_found_reg, out_found_next;
    logic [15:0]   out_count_reg, out_count_next;
    logic [15:0]   out_key_reg, out_key_next;
    logic [4:0]    out_occ_reg, out_occ_next;
    logic [2:0]    out_status_reg, out_status_next;

    logic          accept;
    logic          upd;
    logic          full;
    logic [KW-1:0] in_key;
    logic [KW-1:0] cell_key_in;
    ckt_pkg::cell_ctl_t ctl;

    ckt_pkg::cell_link_t link [CAPACITY+1];
    logic [KW-1:0]       sk   [CAPACITY+1];
    logic [CW-1:0]       sc   [CAPACITY+1];
    logic                sv   [CAPACITY+1];
    ckt_pkg::cell_rep_t  rep  [CAPACITY];
    logic [KW-1:0]       pk   [CAPACITY];
    logic [CW-1:0]       pc   [CAPACITY];

    logic [CAPACITY-1:0] pick_vec;
    logic [CAPACITY-1:0] valid_vec;
    logic                match_any;
    logic                pick_any;
    logic                sat_any;
    logic [KW-1:0]       pick_key_any;
    logic [CW-1:0]       pick_count_any;

    assign in_key      = s_tdata[KW-1:0];
    assign accept      = s_tvalid && s_tready;
    assign s_tready    = (state_reg == S_IDLE);
    assign upd         = (state_reg == S_EXEC) && (!out_valid_reg || m_tready);
    assign full        = (used_reg == UW'(CAPACITY));
    assign cell_key_in = (state_reg == S_IDLE) ? in_key : key_reg;

    always_comb
    begin
        ctl.capture = accept;
        ctl.upd     = upd;
        ctl.cmd     = cmd_reg;
        ctl.append  = !found_reg && !full;
    end

    assign link[0]      = '{valid: 1'b1, seen: 1'b0, del: 1'b0};
    assign sk[CAPACITY] = '0;
    assign sc[CAPACITY] = '0;
    assign sv[CAPACITY] = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        ckt_cell #(
            .INDEX (g),
            .KW    (KW),
            .CW    (CW)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctl          (ctl),
            .cmd_key      (cell_key_in),
            .pos          (pos_reg),
            .left         (link[g]),
            .right        (link[g+1]),
            .nxt_key      (sk[g+1]),
            .nxt_count    (sc[g+1]),
            .nxt_valid    (sv[g+1]),
            .stored_key   (sk[g]),
            .stored_count (sc[g]),
            .stored_valid (sv[g]),
            .rep          (rep[g]),
            .pick_key     (pk[g]),
            .pick_count   (pc[g])
        );
        assign pick_vec[g]  = rep[g].pick;
        assign valid_vec[g] = sv[g];
    end

    // at most one cell picks, so the reports simply OR together
    always_comb
    begin
        match_any      = 1'b0;
        sat_any        = 1'b0;
        pick_key_any   = '0;
        pick_count_any = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            match_any      = match_any | rep[i].match;
            sat_any        = sat_any | rep[i].sat;
            pick_key_any   = pick_key_any | pk[i];
            pick_count_any = pick_count_any | pc[i];
        end
        pick_any = |pick_vec;
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        pos_next        = pos_reg;
        found_next      = found_reg;
        used_next       = used_reg;
        out_valid_next  = out_valid_reg;
        out_found_next  = out_found_reg;
        out_count_next  = out_count_reg;
        out_key_next    = out_key_reg;
        out_occ_next    = out_occ_reg;
        out_status_next = out_status_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            cmd_next   = s_tuser;
            key_next   = in_key;
            pos_next   = s_tdata[19:16];
            found_next = match_any;
            state_next = S_EXEC;
        end

        if (upd)
        begin
            out_key_next = 16'h0000;
            unique case (cmd_reg)
                ckt_pkg::CMD_ADD:
                begin
                    out_found_next = found_reg;
                    if (found_reg)
                    begin
                        out_count_next  = 16'(pick_count_any);
                        out_status_next = sat_any ? ckt_pkg::ST_SAT : ckt_pkg::ST_OK;
                    end
                    else if (full)
                    begin
                        out_count_next  = 16'h0000;
                        out_status_next = ckt_pkg::ST_FULL;
                    end
                    else
                    begin
                        out_count_next  = 16'h0001;
                        out_status_next = ckt_pkg::ST_OK;
                        used_next       = used_reg + UW'(1);
                    end
                end
                ckt_pkg::CMD_REMOVE, ckt_pkg::CMD_QUERY:
                begin
                    out_found_next  = found_reg;
                    out_count_next  = 16'(pick_count_any);
                    out_status_next = found_reg ? ckt_pkg::ST_OK : ckt_pkg::ST_NOT_FOUND;
                    if (link[CAPACITY].del)
                    begin
                        used_next = used_reg - UW'(1);
                    end
                end
                default:
                begin
                    out_found_next  = pick_any;
                    out_count_next  = 16'(pick_count_any);
                    out_key_next    = 16'(pick_key_any);
                    out_status_next = pick_any ? ckt_pkg::ST_OK : ckt_pkg::ST_RANGE;
                end
            endcase
            out_occ_next   = 5'(used_next);
            out_valid_next = 1'b1;
            state_next     = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            found_reg     <= 1'b0;
            used_reg      <= UW'(ckt_pkg::PRESET_N);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            found_reg     <= found_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        pos_reg        <= pos_next;
        out_found_reg  <= out_found_next;
        out_count_reg  <= out_count_next;
        out_key_reg    <= out_key_next;
        out_occ_reg    <= out_occ_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_occ_reg, out_key_reg, out_count_reg};
    assign m_tuser  = {out_status_reg, out_found_reg};

`ifndef SYNTHESIS
    a_one_pick: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |-> $onehot0(pick_vec))
        else $error("more than one cell selected");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= UW'(CAPACITY))
        else $error("occupancy beyond capacity");

    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(used_reg))
        else $error("cell valid bits disagree with occupancy");

    a_result_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        upd |=> (m_tvalid && (state_reg == S_IDLE)))
        else $error("update did not produce a result beat");
`endif

endmodule
